// ===== src/rhss_pkg.sv =====
package rhss_pkg;

  localparam int MAX_PATTERN    = 64;
  localparam int PAT_IDX_W      = $clog2(MAX_PATTERN);
  localparam int PAT_LEN_W      = $clog2(MAX_PATTERN + 1);
  localparam int POSITION_WIDTH = 32;
  localparam int HASH_W         = 28;
  localparam int MUL_CNT_W      = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] HASH_PRIME      = 28'd179424691;
  localparam logic [HASH_W-1:0] HASH_BASE_RESET = 28'd256;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAT_HASH,
    ST_PAT_POW,
    ST_TXT_HASH,
    ST_TXT_OLD,
    ST_TXT_CHECK,
    ST_VER_RD,
    ST_VER_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic       last_flag;
  } item_t;

  typedef struct packed {
    logic [POSITION_WIDTH-1:0] match_start;
    logic                      is_match;
    logic                      text_done;
    logic                      pattern_overflow;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] prod;
  } mm_rsp_t;

  // both operands below the prime
  function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] x,
                                                input logic [HASH_W-1:0] y);
    logic [HASH_W:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum >= {1'b0, HASH_PRIME}) begin
      sum = sum - {1'b0, HASH_PRIME};
    end
    return sum[HASH_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] mod_sub(input logic [HASH_W-1:0] x,
                                                input logic [HASH_W-1:0] y);
    logic [HASH_W-1:0] diff;
    if (x >= y) begin
      diff = x - y;
    end else begin
      diff = x - y + HASH_PRIME;
    end
    return diff;
  endfunction

endpackage

// ===== src/rhss_if.sv =====
interface rhss_item_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  logic       last_flag;

  modport source(output valid, opcode, data_byte, last_flag, input ready);
  modport sink(input valid, opcode, data_byte, last_flag, output ready);
endinterface

interface rhss_result_if import rhss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [POSITION_WIDTH-1:0] match_start;
  logic                      is_match;
  logic                      text_done;
  logic                      pattern_overflow;

  modport source(output valid, match_start, is_match, text_done, pattern_overflow,
                 input ready);
  modport sink(input valid, match_start, is_match, text_done, pattern_overflow,
               output ready);
endinterface

// ===== src/rhss_mulmod.sv =====
module rhss_mulmod import rhss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  logic                 busy;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt;
  logic [HASH_W-1:0]    mcand;
  logic [HASH_W-1:0]    mplier;
  logic [HASH_W-1:0]    acc;
  logic [HASH_W-1:0]    dbl;
  logic [HASH_W-1:0]    acc_next;

  // one multiplier bit a cycle, most significant first
  always_comb begin
    dbl      = mod_add(acc, acc);
    acc_next = mod_add(dbl, mplier[HASH_W-1] ? mcand : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        cnt    <= MUL_CNT_W'(HASH_W - 1);
        acc    <= '0;
        mcand  <= req.a;
        mplier <= req.b;
      end else if (busy) begin
        acc    <= acc_next;
        mplier <= mplier << 1;
        if (cnt == '0) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc;

endmodule

// ===== src/rhss_ctrl.sv =====
module rhss_ctrl import rhss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [HASH_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  input  item_t             in_item,
  output logic              in_ready,
  output mm_req_t           mm_req,
  input  mm_rsp_t           mm_rsp,
  input  logic              out_free,
  output logic              res_push,
  output result_t           res
);

  state_t state;
  state_t state_next;

  logic [HASH_W-1:0]         hash_base;
  logic [HASH_W-1:0]         base_r;
  logic [7:0]                byte_r;
  logic                      last_r;
  logic [PAT_LEN_W-1:0]      pat_len;
  logic [HASH_W-1:0]         phash;
  logic [HASH_W-1:0]         bpow;
  logic                      ovf;
  logic                      pat_closed;
  logic [HASH_W-1:0]         wh;
  logic [HASH_W-1:0]         wh_tmp;
  logic [PAT_LEN_W-1:0]      fill;
  logic [PAT_IDX_W-1:0]      ptr;
  logic [POSITION_WIDTH-1:0] pos;
  logic [POSITION_WIDTH-1:0] cur;
  logic                      hit;
  logic [PAT_LEN_W-1:0]      vk;
  logic [PAT_IDX_W-1:0]      vidx;
  logic                      issued;

  logic [7:0] pat_mem [MAX_PATTERN];
  logic [7:0] win_mem [MAX_PATTERN];
  logic [7:0] pat_rd;
  logic [7:0] win_rd;

  logic                      accept;
  logic                      mm_start;
  logic [PAT_LEN_W-1:0]      len_eff;
  logic                      pat_room;
  logic                      pat_we;
  logic                      win_we;
  logic                      window_full;
  logic [PAT_IDX_W-1:0]      win_rd_addr;
  logic [PAT_LEN_W-1:0]      ptr_inc;
  logic [PAT_IDX_W-1:0]      ptr_wrap;
  logic [PAT_LEN_W-1:0]      vidx_inc;
  logic [PAT_IDX_W-1:0]      vidx_wrap;
  logic [PAT_LEN_W-1:0]      vk_inc;
  logic [POSITION_WIDTH-1:0] len_m1;
  logic [POSITION_WIDTH-1:0] start_off;

  always_comb begin
    accept      = in_valid && in_ready;
    len_eff     = pat_closed ? '0 : pat_len;
    pat_room    = len_eff < PAT_LEN_W'(MAX_PATTERN);
    pat_we      = accept && (in_item.opcode == OP_PATTERN) && pat_room;
    win_we      = (state == ST_TXT_OLD) && mm_rsp.done;
    window_full = fill >= pat_len;
    ptr_inc     = {1'b0, ptr} + 1'b1;
    ptr_wrap    = (ptr_inc >= pat_len) ? '0 : ptr_inc[PAT_IDX_W-1:0];
    vidx_inc    = {1'b0, vidx} + 1'b1;
    vidx_wrap   = (vidx_inc >= pat_len) ? '0 : vidx_inc[PAT_IDX_W-1:0];
    vk_inc      = vk + 1'b1;
    len_m1      = {{(POSITION_WIDTH - PAT_LEN_W){1'b0}}, pat_len - PAT_LEN_W'(1)};
    start_off   = (cur >= len_m1) ? cur - len_m1 : '0;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_item.opcode == OP_PATTERN) begin
            state_next = pat_room ? ST_PAT_HASH : ST_IDLE;
          end else if (pat_len != '0) begin
            state_next = ST_TXT_HASH;
          end else begin
            state_next = in_item.last_flag ? ST_EMIT : ST_IDLE;
          end
        end
      end
      ST_PAT_HASH: if (mm_rsp.done) state_next = ST_PAT_POW;
      ST_PAT_POW:  if (mm_rsp.done) state_next = ST_IDLE;
      ST_TXT_HASH: if (mm_rsp.done) state_next = ST_TXT_OLD;
      ST_TXT_OLD:  if (mm_rsp.done) state_next = ST_TXT_CHECK;
      ST_TXT_CHECK: begin
        if (window_full && (wh == phash)) begin
          state_next = ST_VER_RD;
        end else begin
          state_next = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_VER_RD: state_next = ST_VER_CMP;
      ST_VER_CMP: begin
        if (win_rd != pat_rd) begin
          state_next = last_r ? ST_EMIT : ST_IDLE;
        end else if (vk_inc == pat_len) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_VER_RD;
        end
      end
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    mm_start    = (state inside {ST_PAT_HASH, ST_PAT_POW, ST_TXT_HASH, ST_TXT_OLD})
                  && !issued;
    win_rd_addr = (state == ST_VER_RD) ? vidx : ptr;
    res_push    = (state == ST_EMIT) && out_free;
    mm_req.start = mm_start;
    case (state)
      ST_PAT_HASH: begin
        mm_req.a = phash;
        mm_req.b = base_r;
      end
      ST_PAT_POW: begin
        mm_req.a = bpow;
        mm_req.b = base_r;
      end
      ST_TXT_HASH: begin
        mm_req.a = wh;
        mm_req.b = base_r;
      end
      ST_TXT_OLD: begin
        mm_req.a = bpow;
        mm_req.b = window_full ? HASH_W'(win_rd) : '0;
      end
      default: begin
        mm_req.a = '0;
        mm_req.b = '0;
      end
    endcase
    res.match_start      = hit ? start_off : '0;
    res.is_match         = hit;
    res.text_done        = last_r;
    res.pattern_overflow = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hash_base  <= HASH_BASE_RESET;
      pat_len    <= '0;
      phash      <= '0;
      bpow       <= HASH_W'(1);
      ovf        <= 1'b0;
      pat_closed <= 1'b0;
      wh         <= '0;
      fill       <= '0;
      ptr        <= '0;
      pos        <= '0;
      issued     <= 1'b0;
      hit        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        hash_base <= cfg_wr_data;
      end
      if (mm_start) begin
        issued <= 1'b1;
      end else if (mm_rsp.done) begin
        issued <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            byte_r <= in_item.data_byte;
            last_r <= in_item.last_flag;
            base_r <= (hash_base >= HASH_PRIME) ? hash_base - HASH_PRIME : hash_base;
            hit    <= 1'b0;
            if (in_item.opcode == OP_PATTERN) begin
              // start a new pattern if the old one was closed; drop the text
              if (pat_closed) begin
                phash <= '0;
                bpow  <= HASH_W'(1);
              end
              pat_closed <= in_item.last_flag;
              if (pat_room) begin
                pat_len <= len_eff + 1'b1;
                if (pat_closed) begin
                  ovf <= 1'b0;
                end
              end else begin
                pat_len <= len_eff;
                ovf     <= 1'b1;
              end
              wh   <= '0;
              fill <= '0;
              ptr  <= '0;
              pos  <= '0;
            end else begin
              pat_closed <= 1'b1;
              cur        <= pos;
              if (pos != '1) begin
                pos <= pos + 1'b1;
              end
            end
          end
        end
        ST_PAT_HASH: if (mm_rsp.done) phash <= mod_add(mm_rsp.prod, HASH_W'(byte_r));
        ST_PAT_POW:  if (mm_rsp.done) bpow <= mm_rsp.prod;
        ST_TXT_HASH: if (mm_rsp.done) wh_tmp <= mod_add(mm_rsp.prod, HASH_W'(byte_r));
        ST_TXT_OLD: begin
          if (mm_rsp.done) begin
            wh  <= mod_sub(wh_tmp, mm_rsp.prod);
            ptr <= ptr_wrap;
            if (!window_full) begin
              fill <= fill + 1'b1;
            end
          end
        end
        ST_TXT_CHECK: begin
          vk   <= '0;
          vidx <= ptr;
        end
        ST_VER_CMP: begin
          if (win_rd == pat_rd) begin
            vk   <= vk_inc;
            vidx <= vidx_wrap;
            if (vk_inc == pat_len) begin
              hit <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_free && last_r) begin
            wh   <= '0;
            fill <= '0;
            ptr  <= '0;
            pos  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[len_eff[PAT_IDX_W-1:0]] <= in_item.data_byte;
    end
    pat_rd <= pat_mem[vk[PAT_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[ptr] <= byte_r;
    end
    win_rd <= win_mem[win_rd_addr];
  end

`ifndef SYNTHESIS
  a_ptr_in_window: assert property (@(posedge clk) disable iff (rst)
    (pat_len == '0) || ({1'b0, ptr} < pat_len))
    else $error("window pointer beyond pattern length");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= pat_len)
    else $error("window fill beyond pattern length");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    pat_len <= PAT_LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  a_push_reason: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res.is_match || res.text_done))
    else $error("result pushed with neither match nor done");

  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mm_rsp.done |-> (state == ST_PAT_HASH || state == ST_PAT_POW ||
                     state == ST_TXT_HASH || state == ST_TXT_OLD))
    else $error("multiplier finished outside a multiply step");
`endif

endmodule

// ===== src/rolling_hash_substring_search.sv =====
// Channel   Direction  Transfer
// bytes     sink       opcode, data_byte, last_flag
// results   source     match_start, is_match, text_done, pattern_overflow
// cfg_wr_*  write      hash_base, taken on any cycle with cfg_wr_en high
//
// A stored pattern byte and a text byte each use the shared modular multiplier,
// 28 shift-add steps, twice; a hash hit adds a read and a compare step per
// byte compared, and a result is handed over in the emit state. A dropped
// pattern byte, or a text byte with no pattern, does not use the multiplier.
// Reset is synchronous and needs no clearing pass. A result waits in the
// output register; a second result holds the sequencer until it is taken.
module rolling_hash_substring_search import rhss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [HASH_W-1:0] cfg_wr_data,
  rhss_item_if.sink         bytes,
  rhss_result_if.source     results
);

  item_t   in_item;
  logic    in_ready;
  mm_req_t mm_req;
  mm_rsp_t mm_rsp;
  logic    out_free;
  logic    res_push;
  result_t res;
  logic    out_valid;
  result_t out_res;

  assign in_item.opcode    = bytes.opcode;
  assign in_item.data_byte = bytes.data_byte;
  assign in_item.last_flag = bytes.last_flag;
  assign bytes.ready       = in_ready;

  rhss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (bytes.valid),
    .in_item    (in_item),
    .in_ready   (in_ready),
    .mm_req     (mm_req),
    .mm_rsp     (mm_rsp),
    .out_free   (out_free),
    .res_push   (res_push),
    .res        (res)
  );

  rhss_mulmod u_mulmod (
    .clk(clk),
    .rst(rst),
    .req(mm_req),
    .rsp(mm_rsp)
  );

  assign out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res <= res;
    end
  end

  assign results.valid            = out_valid;
  assign results.match_start      = out_res.match_start;
  assign results.is_match         = out_res.is_match;
  assign results.text_done        = out_res.text_done;
  assign results.pattern_overflow = out_res.pattern_overflow;

endmodule
